FILE: rtl/lpr_pkg.sv
// Shared types and constants for the line pixel rasterizer.
package lpr_pkg;

  localparam int CoordWidthDef = 12;
  localparam int PenWidth      = 16;
  localparam int QueueDepth    = 2;

  typedef enum logic {
    FuncLoad = 1'b0,
    FuncStep = 1'b1
  } func_e;

endpackage

FILE: rtl/lpr_front.sv
// Front end: accepts words, classifies load/step and precomputes line deltas.
module lpr_front #(
  parameter int CoordWidth = lpr_pkg::CoordWidthDef,
  parameter int CmdWidth   = 6 * CoordWidth + 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  lpr_pkg::func_e         func_i,
  input  logic [CoordWidth-1:0]  start_x_i,
  input  logic [CoordWidth-1:0]  start_y_i,
  input  logic [CoordWidth-1:0]  end_x_i,
  input  logic [CoordWidth-1:0]  end_y_i,
  output logic                   push_o,
  input  logic                   push_ready_i,
  output logic [CmdWidth-1:0]    cmd_o
);
  import lpr_pkg::*;

  typedef struct packed {
    logic                  is_load;
    logic                  step_x_neg;
    logic                  step_y_neg;
    logic [CoordWidth-1:0] x0;
    logic [CoordWidth-1:0] y0;
    logic [CoordWidth-1:0] x1;
    logic [CoordWidth-1:0] y1;
    logic [CoordWidth:0]   abs_dx;
    logic [CoordWidth:0]   abs_dy;
  } cmd_t;

  logic signed [CoordWidth:0] dx, dy;
  cmd_t                       cmd;

  always_comb begin
    dx = $signed({end_x_i[CoordWidth-1], end_x_i}) - $signed({start_x_i[CoordWidth-1], start_x_i});
    dy = $signed({end_y_i[CoordWidth-1], end_y_i}) - $signed({start_y_i[CoordWidth-1], start_y_i});
    cmd.is_load    = (func_i == FuncLoad);
    cmd.step_x_neg = !($signed(start_x_i) < $signed(end_x_i));
    cmd.step_y_neg = !($signed(start_y_i) < $signed(end_y_i));
    cmd.x0         = start_x_i;
    cmd.y0         = start_y_i;
    cmd.x1         = end_x_i;
    cmd.y1         = end_y_i;
    cmd.abs_dx     = dx[CoordWidth] ? (-dx) : dx;
    cmd.abs_dy     = dy[CoordWidth] ? (-dy) : dy;
  end

  assign in_ready_o = push_ready_i;
  assign push_o     = in_valid_i & push_ready_i;
  assign cmd_o      = CmdWidth'(cmd);

  push_ready_when_pushing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (push_ready_i && in_valid_i))
    else $error("front pushed into a full queue");

  load_dir_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && cmd.abs_dx == '0) |-> cmd.step_x_neg)
    else $error("equal x must give a negative step direction");

  abs_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (!cmd.abs_dx[CoordWidth] || cmd.abs_dx == {1'b1, {CoordWidth{1'b0}}}) == 1'b1
      || cmd.abs_dx[CoordWidth] == 1'b0)
    else $error("delta magnitude out of range");

endmodule

FILE: rtl/lpr_queue.sv
// Short command queue between the front end and the stepping engine.
module lpr_queue #(
  parameter int Width = 8,
  parameter int Depth = lpr_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o
);
  import lpr_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count overflow");

  push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a push");

  pop_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count missed a pop");

endmodule

FILE: rtl/lpr_back.sv
// Stepping engine: Bresenham state, pixel generation and output register.
module lpr_back #(
  parameter int CoordWidth = lpr_pkg::CoordWidthDef,
  parameter int CmdWidth   = 6 * CoordWidth + 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_pop_o,
  input  logic [CmdWidth-1:0]           cmd_i,
  input  logic [lpr_pkg::PenWidth-1:0]  pen_color_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [CoordWidth-1:0]         pixel_x_o,
  output logic [CoordWidth-1:0]         pixel_y_o,
  output logic [lpr_pkg::PenWidth-1:0]  pixel_color_o,
  output logic                          last_pixel_o
);
  import lpr_pkg::*;

  typedef struct packed {
    logic                  is_load;
    logic                  step_x_neg;
    logic                  step_y_neg;
    logic [CoordWidth-1:0] x0;
    logic [CoordWidth-1:0] y0;
    logic [CoordWidth-1:0] x1;
    logic [CoordWidth-1:0] y1;
    logic [CoordWidth:0]   abs_dx;
    logic [CoordWidth:0]   abs_dy;
  } cmd_t;

  localparam int ErrW = CoordWidth + 2;
  localparam int E2W  = CoordWidth + 3;

  cmd_t                   cmd;
  logic [CoordWidth-1:0]  cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CoordWidth-1:0]  tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [CoordWidth:0]    delta_x_q, delta_x_d, ndelta_y_q, ndelta_y_d;
  logic [ErrW-1:0]        err_q, err_d;
  logic                   sx_neg_q, sx_neg_d, sy_neg_q, sy_neg_d;
  logic                   active_q, active_d;
  logic                   out_valid_q, out_valid_d;
  logic [CoordWidth-1:0]  px_q, px_d, py_q, py_d;
  logic [PenWidth-1:0]    pcol_q, pcol_d;
  logic                   plast_q, plast_d;
  logic                   out_free, do_pop, emit, at_end, adv_x, adv_y;
  logic signed [E2W-1:0]  e2, ndy_ext, dx_ext, err_sum;

  assign cmd       = cmd_t'(cmd_i);
  assign out_free  = !out_valid_q || out_ready_i;
  assign cmd_pop_o = cmd_valid_i && (cmd.is_load || !active_q || out_free);
  assign do_pop    = cmd_pop_o;
  assign emit      = do_pop && !cmd.is_load && active_q;
  assign at_end    = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);

  always_comb begin
    e2      = $signed({err_q, 1'b0});
    ndy_ext = $signed({{2{ndelta_y_q[CoordWidth]}}, ndelta_y_q});
    dx_ext  = $signed({2'b00, delta_x_q});
    adv_x   = (e2 > ndy_ext);
    adv_y   = (e2 < dx_ext);
    err_sum = $signed({err_q[ErrW-1], err_q}) + (adv_x ? ndy_ext : '0)
            + (adv_y ? dx_ext : '0);
  end

  always_comb begin
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    tgt_x_d    = tgt_x_q;
    tgt_y_d    = tgt_y_q;
    delta_x_d  = delta_x_q;
    ndelta_y_d = ndelta_y_q;
    err_d      = err_q;
    sx_neg_d   = sx_neg_q;
    sy_neg_d   = sy_neg_q;
    active_d   = active_q;
    if (do_pop && cmd.is_load) begin
      cur_x_d    = cmd.x0;
      cur_y_d    = cmd.y0;
      tgt_x_d    = cmd.x1;
      tgt_y_d    = cmd.y1;
      delta_x_d  = cmd.abs_dx;
      ndelta_y_d = -cmd.abs_dy;
      err_d      = ErrW'({1'b0, cmd.abs_dx}) - ErrW'({1'b0, cmd.abs_dy});
      sx_neg_d   = cmd.step_x_neg;
      sy_neg_d   = cmd.step_y_neg;
      active_d   = 1'b1;
    end else if (emit) begin
      if (at_end) begin
        active_d = 1'b0;
      end else begin
        err_d = err_sum[ErrW-1:0];
        if (adv_x) begin
          cur_x_d = sx_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
        end
        if (adv_y) begin
          cur_y_d = sy_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    px_d        = px_q;
    py_d        = py_q;
    pcol_d      = pcol_q;
    plast_d     = plast_q;
    if (emit) begin
      out_valid_d = 1'b1;
      px_d        = cur_x_q;
      py_d        = cur_y_q;
      pcol_d      = pen_color_i;
      plast_d     = at_end;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      delta_x_q   <= '0;
      ndelta_y_q  <= '0;
      err_q       <= '0;
      sx_neg_q    <= 1'b0;
      sy_neg_q    <= 1'b0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      tgt_x_q     <= tgt_x_d;
      tgt_y_q     <= tgt_y_d;
      delta_x_q   <= delta_x_d;
      ndelta_y_q  <= ndelta_y_d;
      err_q       <= err_d;
      sx_neg_q    <= sx_neg_d;
      sy_neg_q    <= sy_neg_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q    <= px_d;
    py_q    <= py_d;
    pcol_q  <= pcol_d;
    plast_q <= plast_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = pcol_q;
  assign last_pixel_o  = plast_q;

  last_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && at_end) |=> !active_q)
    else $error("generator still active after last pixel");

  load_goes_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && cmd.is_load) |=> active_q)
    else $error("load did not start the generator");

  no_emit_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("pixel emitted over a pending word");

  ndy_nonpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (ndelta_y_q[CoordWidth] || ndelta_y_q == '0))
    else $error("negated y distance is positive");

endmodule

FILE: rtl/line_pixel_rasterizer.sv
// Top level of the Bresenham line pixel rasterizer.
// Path: a step word passes the command queue, then the engine output register, before its pixel is valid on m_axis.
// Throughput: one word per cycle in, one pixel per cycle out while m_axis_tready is high;
//   a 2-entry command queue between front end and stepping engine absorbs short output stalls.
// Reset: asynchronous, active low; generator idle, pen color zero, queue empty.
module line_pixel_rasterizer #(
  parameter int CoordWidth = lpr_pkg::CoordWidthDef
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // start_x, start_y, end_x, end_y from bit 0 up, zero padded to bytes
  input  logic [((4*CoordWidth+7)/8)*8-1:0]            s_axis_tdata,
  // func
  input  logic                                         s_axis_tuser,
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // pixel_x, pixel_y, pixel_color from bit 0 up, zero padded to bytes
  output logic [((2*CoordWidth+lpr_pkg::PenWidth+7)/8)*8-1:0] m_axis_tdata,
  // last_pixel
  output logic                                         m_axis_tlast,
  input  logic                                         cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  logic [lpr_pkg::PenWidth-1:0]                 cfg_data_i
);
  import lpr_pkg::*;

  localparam int CmdWidth = 6 * CoordWidth + 5;
  localparam int MDataW   = ((2 * CoordWidth + PenWidth + 7) / 8) * 8;

  logic [PenWidth-1:0]   pen_color_q;
  logic                  push, push_ready, q_valid, q_pop;
  logic [CmdWidth-1:0]   cmd_in, cmd_out;
  logic [CoordWidth-1:0] pixel_x, pixel_y;
  logic [PenWidth-1:0]   pixel_color;
  func_e                 func;

  assign cfg_ready_o = 1'b1;
  assign func        = func_e'(s_axis_tuser);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_color_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pen_color_q <= cfg_data_i;
    end
  end

  lpr_front #(
    .CoordWidth (CoordWidth),
    .CmdWidth   (CmdWidth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .func_i       (func),
    .start_x_i    (s_axis_tdata[CoordWidth-1:0]),
    .start_y_i    (s_axis_tdata[2*CoordWidth-1:CoordWidth]),
    .end_x_i      (s_axis_tdata[3*CoordWidth-1:2*CoordWidth]),
    .end_y_i      (s_axis_tdata[4*CoordWidth-1:3*CoordWidth]),
    .push_o       (push),
    .push_ready_i (push_ready),
    .cmd_o        (cmd_in)
  );

  lpr_queue #(
    .Width (CmdWidth),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (cmd_in),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (cmd_out)
  );

  lpr_back #(
    .CoordWidth (CoordWidth),
    .CmdWidth   (CmdWidth)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_pop_o     (q_pop),
    .cmd_i         (cmd_out),
    .pen_color_i   (pen_color_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .pixel_color_o (pixel_color),
    .last_pixel_o  (m_axis_tlast)
  );

  assign m_axis_tdata = MDataW'({pixel_color, pixel_y, pixel_x});

endmodule
